>>> rtl/core/mhpq_pkg.sv
// Shared types, codes and the sequencer's control store for the min-heap priority queue.
// Used by min_heap_priority_queue; depends on nothing else.
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 32;

   // operation codes carried in the mode field
   localparam logic [1:0] MODE_INSERT   = 2'd0;
   localparam logic [1:0] MODE_DECREASE = 2'd1;
   localparam logic [1:0] MODE_EXTRACT  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_BAD_SLOT = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key;
      logic [5:0]  slot;
      logic [31:0] amount;
   } req_type;

   typedef struct packed {
      logic [31:0] min_key;
      logic [1:0]  status;
      logic [6:0]  entries;
   } rsp_type;

   // sequencer steps
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DEC_RD,
      ST_DEC_SUB,
      ST_EXT_RD,
      ST_EXT_TAKE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_UP_PUT,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DN_PUT,
      ST_RESP
   } step_type;

   // datapath actions
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_START,
      OP_READ_SLOT,
      OP_SUBTRACT,
      OP_READ_ENDS,
      OP_TAKE_MIN,
      OP_READ_PARENT,
      OP_MOVE_UP,
      OP_PUT,
      OP_READ_KIDS,
      OP_MOVE_DOWN,
      OP_RESPOND
   } op_type;

   // jump kinds: HOLD kinds stay on the step until their condition is met
   typedef enum logic [3:0] {
      J_NEXT,
      J_GOTO,
      J_HOLD_REQ,
      J_HOLD_OUT,
      J_DISPATCH,
      J_IF_ROOT,
      J_IF_UP,
      J_IF_LEAF,
      J_IF_DOWN
   } jump_type;

   typedef struct packed {
      op_type   op;
      jump_type jmp;
      step_type target;
   } ucode_type;

   // control store
   function automatic ucode_type ucode(input step_type step);
      ucode_type cw;
      unique case (step)
         ST_IDLE:     cw = '{op: OP_ACCEPT,      jmp: J_HOLD_REQ, target: ST_START};
         ST_START:    cw = '{op: OP_START,       jmp: J_DISPATCH, target: ST_IDLE};
         ST_DEC_RD:   cw = '{op: OP_READ_SLOT,   jmp: J_NEXT,     target: ST_IDLE};
         ST_DEC_SUB:  cw = '{op: OP_SUBTRACT,    jmp: J_GOTO,     target: ST_UP_RD};
         ST_EXT_RD:   cw = '{op: OP_READ_ENDS,   jmp: J_NEXT,     target: ST_IDLE};
         ST_EXT_TAKE: cw = '{op: OP_TAKE_MIN,    jmp: J_GOTO,     target: ST_DN_RD};
         ST_UP_RD:    cw = '{op: OP_READ_PARENT, jmp: J_IF_ROOT,  target: ST_UP_PUT};
         ST_UP_CMP:   cw = '{op: OP_MOVE_UP,     jmp: J_IF_UP,    target: ST_UP_RD};
         ST_UP_PUT:   cw = '{op: OP_PUT,         jmp: J_GOTO,     target: ST_RESP};
         ST_DN_RD:    cw = '{op: OP_READ_KIDS,   jmp: J_IF_LEAF,  target: ST_DN_PUT};
         ST_DN_CMP:   cw = '{op: OP_MOVE_DOWN,   jmp: J_IF_DOWN,  target: ST_DN_RD};
         ST_DN_PUT:   cw = '{op: OP_PUT,         jmp: J_NEXT,     target: ST_IDLE};
         ST_RESP:     cw = '{op: OP_RESPOND,     jmp: J_HOLD_OUT, target: ST_IDLE};
         default:     cw = '{op: OP_NONE,        jmp: J_GOTO,     target: ST_IDLE};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: microcoded sequencer, heap memory and result register.
// Depends on mhpq_pkg (types, codes, control store).
//
// Usage
//   req channel (req_valid/req_ready/req_data) takes one item: insert a key, decrease the key
//   at a heap slot (saturating at zero), or extract the minimum. rsp channel returns exactly
//   one item per request: the extracted minimum, a status code and the entry count after it.
// Timing
//   One item at a time: a new item is taken only when the sequencer is back in its idle step.
//   A moving key passes the heap levels one by one; each level has a read step, which issues
//   the memory read, and a compare step, which compares the registered data and writes.
//   A key that comes to rest at the root or on a leaf skips the last compare.
// Reset
//   Synchronous, active high. Clears the entry count, the sequencer and the response valid.
//   Heap memory is not cleared; reads may touch unused slots, but only data from filled slots is used.
// Back-pressure
//   The result sits in an output register. A stalled receiver only holds the sequencer in
//   its respond step; a new item is taken as soon as that register has been loaded.
`default_nettype none

module min_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  mhpq_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output mhpq_pkg::rsp_type  rsp_data
);

   import mhpq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = IDX_W + 2;     // child index width, holds 2*CAPACITY
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // heap storage: one write port, two registered read ports
   logic [KEY_BITS-1:0] heap_mem [CAPACITY];
   logic [IDX_W-1:0]    raddr0, raddr1, wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic                wr_en;
   logic [KEY_BITS-1:0] rdata0_ff, rdata1_ff;

   // sequencer and datapath registers
   step_type            step_ff, step_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] min_key_ff, min_key_in;
   logic [1:0]          status_ff, status_in;
   req_type             req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   ucode_type           cw;
   step_type            dispatch_step;
   step_type            step_next;

   // address arithmetic
   logic [IDX_W-1:0]    parent_idx;
   logic [CW-1:0]       left_w, right_w, count_w;
   logic                at_root, up_move, at_leaf, moved;
   logic                left_less, right_less;
   logic [KEY_BITS-1:0] best0_v, best_v;
   logic [IDX_W-1:0]    best0_i, best_i;

   // width adaptation between the fixed 32-bit fields and the stored key width
   logic [63:0]         key_wide, amount_wide, min_wide;
   logic [KEY_BITS-1:0] key_k, amount_k;
   logic [31:0]         slot_wide, count_wide;
   logic                out_free, accept;

   assign key_wide    = 64'(req_ff.key);
   assign amount_wide = 64'(req_ff.amount);
   assign key_k       = key_wide[KEY_BITS-1:0];
   assign amount_k    = amount_wide[KEY_BITS-1:0];
   assign min_wide    = 64'(min_key_ff);
   assign slot_wide   = 32'(req_ff.slot);
   assign count_wide  = 32'(count_ff);

   assign cw       = ucode(step_ff);
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (step_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign parent_idx = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign left_w     = CW'({pos_ff, 1'b1});
   assign right_w    = left_w + CW'(1);
   assign count_w    = CW'(count_ff);
   assign at_root    = (pos_ff == '0);
   assign up_move    = (rdata0_ff > key_ff);
   assign at_leaf    = (left_w >= count_w);

   // sift-down pick: left only if strictly smaller, right only if strictly smaller still
   always_comb begin
      left_less  = (rdata0_ff < key_ff);
      best0_v    = left_less ? rdata0_ff : key_ff;
      best0_i    = left_less ? left_w[IDX_W-1:0] : pos_ff;
      right_less = (right_w < count_w) && (rdata1_ff < best0_v);
      best_v     = right_less ? rdata1_ff : best0_v;
      best_i     = right_less ? right_w[IDX_W-1:0] : best0_i;
      moved      = left_less || right_less;
   end

   // read addresses per step
   always_comb begin
      raddr0 = '0;
      raddr1 = '0;
      unique case (cw.op)
         OP_READ_SLOT:   raddr0 = pos_ff;
         OP_READ_ENDS:   raddr1 = count_ff[IDX_W-1:0];
         OP_READ_PARENT: raddr0 = parent_idx;
         OP_READ_KIDS: begin
            raddr0 = left_w[IDX_W-1:0];
            raddr1 = right_w[IDX_W-1:0];
         end
         default: ;
      endcase
   end

   // single write port: hole moves during sifts, key lands at the end
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = key_ff;
      unique case (cw.op)
         OP_MOVE_UP: begin
            wr_en   = up_move;
            wr_data = rdata0_ff;
         end
         OP_MOVE_DOWN: begin
            wr_en   = moved;
            wr_data = best_v;
         end
         OP_PUT: wr_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rdata0_ff <= heap_mem[raddr0];
      rdata1_ff <= heap_mem[raddr1];
   end

   // operation decode at the start step: checks and entry point
   always_comb begin
      dispatch_step = ST_RESP;
      unique case (req_ff.mode)
         MODE_INSERT:   if (count_ff < CAP_CNT) dispatch_step = ST_UP_RD;
         MODE_DECREASE: if (slot_wide < count_wide) dispatch_step = ST_DEC_RD;
         MODE_EXTRACT:  if (count_ff != '0) dispatch_step = ST_EXT_RD;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      min_key_in   = min_key_ff;
      status_in    = status_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (cw.op)
         OP_ACCEPT: if (accept) req_in = req_data;
         OP_START: begin
            status_in  = STATUS_OK;
            min_key_in = '0;
            unique case (req_ff.mode)
               MODE_INSERT: begin
                  if (count_ff < CAP_CNT) begin
                     pos_in   = count_ff[IDX_W-1:0];
                     key_in   = key_k;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     status_in = STATUS_FULL;
                  end
               end
               MODE_DECREASE: begin
                  if (slot_wide < count_wide) begin
                     pos_in = slot_wide[IDX_W-1:0];
                  end else begin
                     status_in = STATUS_BAD_SLOT;
                  end
               end
               MODE_EXTRACT: begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     status_in = STATUS_EMPTY;
                  end
               end
               default: ;
            endcase
         end
         OP_SUBTRACT: key_in = (amount_k >= rdata0_ff) ? '0 : (rdata0_ff - amount_k);
         OP_TAKE_MIN: begin
            min_key_in = rdata0_ff;   // root
            key_in     = rdata1_ff;   // former last entry
            pos_in     = '0;
         end
         OP_MOVE_UP:   if (up_move) pos_in = parent_idx;
         OP_MOVE_DOWN: if (moved) pos_in = best_i;
         OP_RESPOND: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.min_key = min_wide[31:0];
               rsp_data_in.status  = status_ff;
               rsp_data_in.entries = count_wide[6:0];
            end
         end
         default: ;
      endcase
   end

   // step sequencing
   always_comb begin
      step_next = step_type'(4'(step_ff) + 4'd1);
      unique case (cw.jmp)
         J_NEXT:     step_in = step_next;
         J_GOTO:     step_in = cw.target;
         J_HOLD_REQ: step_in = accept ? cw.target : step_ff;
         J_HOLD_OUT: step_in = out_free ? cw.target : step_ff;
         J_DISPATCH: step_in = dispatch_step;
         J_IF_ROOT:  step_in = at_root ? cw.target : step_next;
         J_IF_UP:    step_in = up_move ? cw.target : step_next;
         J_IF_LEAF:  step_in = at_leaf ? cw.target : step_next;
         J_IF_DOWN:  step_in = moved ? cw.target : step_next;
         default:    step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      min_key_ff  <= min_key_in;
      status_ff   <= status_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count beyond capacity");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff == ST_START))
      else $error("accepted item did not start");

   a_respond_loads: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_RESP && out_free) |=> rsp_valid_ff)
      else $error("result register not loaded");

   a_write_steps: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (step_ff == ST_UP_CMP || step_ff == ST_UP_PUT ||
                 step_ff == ST_DN_CMP || step_ff == ST_DN_PUT))
      else $error("heap written outside a sift step");

   a_sift_ok: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_UP_CMP || step_ff == ST_DN_CMP) |-> (status_ff == STATUS_OK))
      else $error("sift running on a rejected item");

endmodule

`default_nettype wire
